>>> design/tats_pkg.sv
// ----------------------------------------------------------------------------
// tats_pkg
// Shared types and constants for the throttle actuator test sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package tats_pkg;

   // phase codes
   localparam logic [3:0] PH_IDLE  = 4'd0;
   localparam logic [3:0] PH_FIRST = 4'd1;
   localparam logic [3:0] PH_LAST  = 4'd7;
   localparam logic [3:0] PH_END   = 4'd8;

   // step codes
   localparam logic [2:0] STEP_NONE     = 3'd0;
   localparam logic [2:0] STEP_RISE_MAX = 3'd4;

   // configuration register indexes
   localparam logic [2:0] CSR_PHASE_TIMES_A   = 3'd0;
   localparam logic [2:0] CSR_PHASE_TIMES_B   = 3'd1;
   localparam logic [2:0] CSR_POSITION_SET    = 3'd2;
   localparam logic [2:0] CSR_RESPONSE_LIMITS = 3'd3;
   localparam logic [2:0] CSR_TEST_SELECT     = 3'd4;

   localparam int unsigned CSR_DATA_W = 60;

   // saturation limit for all timers and the response count
   localparam logic [14:0] SAT_LIMIT = 15'd30000;

   typedef struct packed {
      logic        test_enable;
      logic [7:0]  requested_code;
      logic [15:0] throttle_position;
   } req_type;

   typedef struct packed {
      logic [9:0]  setpoint_position;
      logic        in_progress;
      logic        completed;
      logic [2:0]  step_index;
      logic [3:0]  sequence_phase;
      logic [14:0] response_time;
      logic        sluggish_fault;
   } rsp_type;

   typedef struct packed {
      logic [59:0] phase_times_a;
      logic [59:0] phase_times_b;
      logic [31:0] position_set;
      logic [31:0] response_limits;
      logic [7:0]  test_select_code;
   } cfg_type;

   typedef struct packed {
      logic [3:0]  phase;
      logic [14:0] phase_timer;
      logic [14:0] hold_timer;
      logic [2:0]  step;
      logic [9:0]  setpoint;
      logic        running;
      logic        done;
      logic        timing;
      logic [14:0] resp_count;
      logic        fault;
   } state_type;

endpackage

`default_nettype wire

>>> design/tats_next.sv
// ----------------------------------------------------------------------------
// tats_next
// Next-state logic for one tick: phase sequencer, then step response timer.
// ----------------------------------------------------------------------------
`default_nettype none

module tats_next (
   input  tats_pkg::state_type cur,
   input  tats_pkg::req_type   item,
   input  tats_pkg::cfg_type   cfg,
   output tats_pkg::state_type nxt
);

   // duration of phase p, or end hold time for the end phase, saturated
   function automatic logic [14:0] duration(input logic [3:0]  p,
                                            input logic [59:0] word_a,
                                            input logic [59:0] word_b);
      logic [59:0] word;
      logic [1:0]  slot;
      logic [14:0] raw;
      word = (p <= 4'd4) ? word_a : word_b;
      slot = 2'(p - 4'd1);
      case (slot)
         2'd0:    raw = word[14:0];
         2'd1:    raw = word[29:15];
         2'd2:    raw = word[44:30];
         default: raw = word[59:45];
      endcase
      return (raw > tats_pkg::SAT_LIMIT) ? tats_pkg::SAT_LIMIT : raw;
   endfunction

   // setpoint for step phases: low, mid, high, mid, low
   function automatic logic [9:0] step_setpoint(input logic [3:0]  p,
                                                input logic [31:0] pset);
      logic [7:0] b;
      case (p)
         4'd3, 4'd5: b = pset[15:8];
         4'd4:       b = pset[23:16];
         default:    b = pset[7:0];
      endcase
      return {b, 2'b00};
   endfunction

   logic        req;
   logic [3:0]  phase_inc;
   logic [15:0] sp_ext;
   logic [15:0] diff;
   logic [15:0] band;
   logic        run;
   logic        stop;
   logic [15:0] limit;
   tats_pkg::state_type seq;

   assign req       = item.test_enable && (item.requested_code == cfg.test_select_code);
   assign phase_inc = cur.phase + 4'd1;

   // sequencer
   always_comb begin
      seq = cur;
      case (cur.phase)
         tats_pkg::PH_IDLE: begin
            if (req) begin
               seq.running     = 1'b1;
               seq.step        = tats_pkg::STEP_NONE;
               seq.phase       = tats_pkg::PH_FIRST;
               seq.phase_timer = duration(tats_pkg::PH_FIRST, cfg.phase_times_a,
                                          cfg.phase_times_b);
               seq.setpoint    = '0;
            end
         end
         tats_pkg::PH_END: begin
            if (req && cur.hold_timer == '0) begin
               seq.phase    = tats_pkg::PH_IDLE;
               seq.setpoint = '0;
               seq.step     = tats_pkg::STEP_NONE;
               seq.done     = 1'b0;
               seq.running  = 1'b0;
            end else if (cur.hold_timer != '0) begin
               seq.hold_timer = cur.hold_timer - 15'd1;
            end
         end
         default: begin
            if (!req || cur.phase > tats_pkg::PH_LAST) begin
               // abort, or an unreachable code
               seq.phase    = tats_pkg::PH_IDLE;
               seq.setpoint = '0;
               seq.step     = tats_pkg::STEP_NONE;
               seq.done     = 1'b0;
               seq.running  = 1'b0;
            end else if (cur.phase_timer <= 15'd1) begin
               if (cur.phase == tats_pkg::PH_LAST) begin
                  seq.phase      = tats_pkg::PH_END;
                  seq.step       = tats_pkg::STEP_NONE;
                  seq.setpoint   = '0;
                  seq.done       = 1'b1;
                  seq.running    = 1'b0;
                  seq.hold_timer = duration(tats_pkg::PH_END, cfg.phase_times_a,
                                            cfg.phase_times_b);
               end else begin
                  seq.phase       = phase_inc;
                  seq.phase_timer = duration(phase_inc, cfg.phase_times_a,
                                             cfg.phase_times_b);
                  if (phase_inc == tats_pkg::PH_LAST) begin
                     seq.step     = tats_pkg::STEP_NONE;
                     seq.setpoint = '0;
                  end else begin
                     seq.step     = phase_inc[2:0];
                     seq.setpoint = step_setpoint(phase_inc, cfg.position_set);
                  end
               end
            end else begin
               seq.phase_timer = cur.phase_timer - 15'd1;
            end
         end
      endcase
   end

   // response timer works on the updated sequencer state
   assign sp_ext = {6'd0, seq.setpoint};
   assign diff   = (item.throttle_position >= sp_ext) ? item.throttle_position - sp_ext
                                                      : sp_ext - item.throttle_position;
   assign band   = {6'd0, cfg.position_set[31:24], 2'b00};
   assign run    = seq.running && (seq.step != cur.step) && (seq.step != tats_pkg::STEP_NONE);
   assign stop   = !seq.running || (diff <= band);
   assign limit  = (seq.step <= tats_pkg::STEP_RISE_MAX) ? cfg.response_limits[15:0]
                                                         : cfg.response_limits[31:16];

   always_comb begin
      nxt = seq;
      if (!cur.timing) begin
         if (run) begin
            nxt.timing     = 1'b1;
            nxt.resp_count = '0;
         end
      end else if (stop) begin
         nxt.timing = 1'b0;
      end else if (cur.resp_count < tats_pkg::SAT_LIMIT) begin
         nxt.resp_count = cur.resp_count + 15'd1;
      end

      if (seq.running && !cur.running) begin
         nxt.fault = 1'b0;
      end
      if (limit <= {1'b0, nxt.resp_count}) begin
         nxt.fault = 1'b1;
      end
   end

endmodule

`default_nettype wire

>>> design/throttle_actuator_test_sequencer.sv
// ----------------------------------------------------------------------------
// throttle_actuator_test_sequencer
// Each request beat is one control tick. While the service is enabled and the
// requested code matches the selected test code, the block walks through
// seven timed phases (zero, low, mid, high, mid, low, zero setpoint), then
// holds an end state with completed set until the hold timer has run out and
// the request is seen again. Dropping the request during a phase aborts to
// idle. On every setpoint step the response time is counted (saturating at
// 30000) until the measured position is inside the band, and a sticky
// sluggish flag is raised when the count reaches the rise or fall limit.
// Every request beat gives exactly one response beat, showing the state after
// that tick. One beat is taken per clock unless a stalled response blocks
// intake; the response appears in the cycle after its request, the rate set by
// the single state register whose next value comes from the current tick.
// Configuration writes are taken at any time but are meant for idle periods.
// ----------------------------------------------------------------------------
`default_nettype none

module throttle_actuator_test_sequencer (
   input  wire                  clock,
   input  wire                  reset,
   // request channel
   input  wire                  req_valid,
   output logic                 req_stall,
   input  tats_pkg::req_type    req_data,
   // response channel
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output tats_pkg::rsp_type    rsp_data,
   // configuration write port
   input  wire                  csr_we,
   input  wire [2:0]            csr_index,
   input  wire [tats_pkg::CSR_DATA_W-1:0] csr_wdata
);

   tats_pkg::cfg_type   cfg_ff;
   tats_pkg::state_type state_ff;
   tats_pkg::state_type state_in;
   tats_pkg::rsp_type   rsp_data_ff;
   tats_pkg::rsp_type   rsp_data_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                accept_in;

   // the output register frees up whenever its beat is taken, so a new
   // request beat can enter in the same cycle
   assign req_stall    = rsp_valid_ff && rsp_stall;
   assign accept_in    = req_valid && !req_stall;
   assign rsp_valid_in = accept_in || (rsp_valid_ff && rsp_stall);

   // whole tick worth of next-state logic
   tats_next u_next (
      .cur  (state_ff),
      .item (req_data),
      .cfg  (cfg_ff),
      .nxt  (state_in)
   );

   // response shows the state after the tick
   always_comb begin
      rsp_data_in.setpoint_position = state_in.setpoint;
      rsp_data_in.in_progress       = state_in.running;
      rsp_data_in.completed         = state_in.done;
      rsp_data_in.step_index        = state_in.step;
      rsp_data_in.sequence_phase    = state_in.phase;
      rsp_data_in.response_time     = state_in.resp_count;
      rsp_data_in.sluggish_fault    = state_in.fault;
   end

   // configuration registers; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            tats_pkg::CSR_PHASE_TIMES_A:   cfg_ff.phase_times_a    <= csr_wdata;
            tats_pkg::CSR_PHASE_TIMES_B:   cfg_ff.phase_times_b    <= csr_wdata;
            tats_pkg::CSR_POSITION_SET:    cfg_ff.position_set     <= csr_wdata[31:0];
            tats_pkg::CSR_RESPONSE_LIMITS: cfg_ff.response_limits  <= csr_wdata[31:0];
            tats_pkg::CSR_TEST_SELECT:     cfg_ff.test_select_code <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // sequencer and timer state, advanced once per accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept_in) begin
            state_ff <= state_in;
         end
      end
   end

   // response payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept_in) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // running and completed are never both set
   a_run_done_excl: assert property (@(posedge clock) disable iff (reset)
      !(state_ff.running && state_ff.done))
      else $error("running and done set together");

   // phase code stays within idle, the seven phases and end hold
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase <= tats_pkg::PH_END)
      else $error("phase code out of range");

   // a setpoint step is only marked while the sequence runs
   a_step_running: assert property (@(posedge clock) disable iff (reset)
      (state_ff.step != tats_pkg::STEP_NONE) |-> state_ff.running)
      else $error("step marked while not running");

   // response count never passes saturation
   a_count_sat: assert property (@(posedge clock) disable iff (reset)
      state_ff.resp_count <= tats_pkg::SAT_LIMIT)
      else $error("response count above saturation");

   // every accepted request beat leaves a response beat pending
   a_beat_out: assert property (@(posedge clock) disable iff (reset)
      accept_in |=> rsp_valid)
      else $error("accepted beat produced no response");
`endif

endmodule

`default_nettype wire
